/* rtl/mac_pkg.sv */
// ----------------------------------------------------------------------------
// mac_pkg
// shared types and constants of the accumulator execute core
// ----------------------------------------------------------------------------
package mac_pkg;

   localparam int DATA_WORDS = 4096;
   localparam int ADDR_BITS  = $clog2(DATA_WORDS);

   localparam logic [31:0] SIGN_BIT  = 32'h8000_0000;
   localparam logic [31:0] BIG_BIT   = 32'h4000_0000;
   localparam logic [31:0] SHAMT_MSK = 32'h0000_001f;

   typedef logic [ADDR_BITS-1:0] addr_type;

   typedef enum logic [6:0] {
      OP_ADD, OP_SUB, OP_OR, OP_AND, OP_XOR, OP_NOT, OP_NEG, OP_SHL, OP_SHR,
      OP_LOAD, OP_STORE, OP_GET, OP_PEEK, OP_KEEP, OP_PUT,
      OP_INC_A, OP_DEC_A, OP_INC_S, OP_DEC_S, OP_INC_D, OP_DEC_D,
      OP_INC_SD, OP_DEC_SD, OP_INC_P, OP_DEC_P,
      OP_IMM_A, OP_IMM_B, OP_IMM_R, OP_IMM_S, OP_IMM_D, OP_IMM_SD, OP_IMM_P,
      OP_MSB_A, OP_MSB_B, OP_MSB_R, OP_MSB_S, OP_MSB_D, OP_MSB_SD, OP_MSB_P,
      OP_SWAP,
      OP_A2B, OP_A2T, OP_A2R, OP_A2S, OP_A2D, OP_A2P, OP_A2PUT,
      OP_B2A, OP_T2A, OP_R2A, OP_S2A, OP_D2A, OP_P2A, OP_PUT2A,
      OP_UNPARK0, OP_UNPARK1, OP_UNPARK2, OP_UNPARK3,
      OP_PARK0, OP_PARK1, OP_PARK2, OP_PARK3,
      OP_T_ZERO, OP_T_MIN, OP_T_NEG, OP_T_BIG,
      OP_T_EQ, OP_T_NE, OP_T_LE, OP_T_GE, OP_T_LT, OP_T_GT,
      OP_REPEAT, OP_MDM, OP_NOP
   } op_type;

endpackage

/* rtl/minimal_accumulator_core_execute_core.sv */
// ----------------------------------------------------------------------------
// minimal_accumulator_core_execute_core
// execute unit of a small accumulator machine with word data memory
// ----------------------------------------------------------------------------
// One instruction per cycle, unless the response channel stalls or a load,
// get or peek waits on the registered read of the single port data memory;
// every other instruction, stores included, needs no wait. After reset the
// core clears all 4096 data words, one a cycle, before req_tready rises.
module minimal_accumulator_core_execute_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // imm
   input  logic [6:0]  req_tuser,   // kind
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // acc
   output logic        rsp_tuser    // taken
);

   logic [31:0] a_ff, b_ff, tmp_ff, put_ff, rep_ff, src_ff, dst_ff, peek_ff;
   logic [31:0] a_in, b_in, tmp_in, put_in, rep_in, src_in, dst_in, peek_in;
   logic [31:0] park_ff [4];
   logic [31:0] park_in [4];
   logic        clr_busy_ff;
   mac_pkg::addr_type clr_cnt_ff;
   logic        pend_ff;
   logic        ov_ff;
   logic [31:0] od_ff;
   logic        ot_ff;

   logic        go, is_load, taken, mem_we;
   logic [31:0] imv, top, mem_wd, mem_rd;
   mac_pkg::addr_type mem_addr;
   mac_pkg::op_type   op;

   assign op   = mac_pkg::op_type'(req_tuser);
   assign imv  = {8'd0, req_tdata};
   assign top  = {req_tdata[7:0], 24'd0};
   assign req_tready = !clr_busy_ff && !pend_ff && (!ov_ff || rsp_tready);
   assign go   = req_tvalid && req_tready;

   always_comb begin
      a_in = a_ff; b_in = b_ff; tmp_in = tmp_ff; put_in = put_ff;
      rep_in = rep_ff; src_in = src_ff; dst_in = dst_ff; peek_in = peek_ff;
      park_in = park_ff;
      taken = 1'b0;
      is_load = 1'b0;
      mem_we = 1'b0;
      mem_wd = a_ff;
      mem_addr = src_ff[mac_pkg::ADDR_BITS-1:0];
      case (op)
         mac_pkg::OP_ADD: a_in = a_ff + b_ff;
         mac_pkg::OP_SUB: a_in = a_ff - b_ff;
         mac_pkg::OP_OR:  a_in = a_ff | b_ff;
         mac_pkg::OP_AND: a_in = a_ff & b_ff;
         mac_pkg::OP_XOR: a_in = a_ff ^ b_ff;
         mac_pkg::OP_NOT: a_in = ~a_ff;
         mac_pkg::OP_NEG: a_in = ~a_ff + 32'd1;
         mac_pkg::OP_SHL: a_in = a_ff << (b_ff & mac_pkg::SHAMT_MSK);
         mac_pkg::OP_SHR: a_in = a_ff >> (b_ff & mac_pkg::SHAMT_MSK);
         mac_pkg::OP_LOAD: is_load = 1'b1;
         mac_pkg::OP_STORE: begin
            mem_we = 1'b1;
            mem_addr = dst_ff[mac_pkg::ADDR_BITS-1:0];
         end
         mac_pkg::OP_GET: begin
            is_load = 1'b1;
            mem_addr = a_ff[mac_pkg::ADDR_BITS-1:0];
         end
         mac_pkg::OP_PEEK: begin
            is_load = 1'b1;
            mem_addr = peek_ff[mac_pkg::ADDR_BITS-1:0];
         end
         mac_pkg::OP_KEEP: begin
            mem_we = 1'b1;
            mem_addr = peek_ff[mac_pkg::ADDR_BITS-1:0];
         end
         mac_pkg::OP_PUT: begin
            mem_we = 1'b1;
            mem_wd = put_ff;
            mem_addr = a_ff[mac_pkg::ADDR_BITS-1:0];
         end
         mac_pkg::OP_INC_A: a_in = a_ff + 32'd1;
         mac_pkg::OP_DEC_A: a_in = a_ff - 32'd1;
         mac_pkg::OP_INC_S: src_in = src_ff + 32'd1;
         mac_pkg::OP_DEC_S: src_in = src_ff - 32'd1;
         mac_pkg::OP_INC_D: dst_in = dst_ff + 32'd1;
         mac_pkg::OP_DEC_D: dst_in = dst_ff - 32'd1;
         mac_pkg::OP_INC_SD: begin
            src_in = src_ff + 32'd1;
            dst_in = dst_ff + 32'd1;
         end
         mac_pkg::OP_DEC_SD: begin
            src_in = src_ff - 32'd1;
            dst_in = dst_ff - 32'd1;
         end
         mac_pkg::OP_INC_P: peek_in = peek_ff + 32'd1;
         mac_pkg::OP_DEC_P: peek_in = peek_ff - 32'd1;
         mac_pkg::OP_IMM_A: a_in = imv;
         mac_pkg::OP_IMM_B: b_in = imv;
         mac_pkg::OP_IMM_R: rep_in = imv;
         mac_pkg::OP_IMM_S: src_in = imv;
         mac_pkg::OP_IMM_D: dst_in = imv;
         mac_pkg::OP_IMM_SD: begin
            src_in = imv;
            dst_in = imv;
         end
         mac_pkg::OP_IMM_P: peek_in = imv;
         mac_pkg::OP_MSB_A: a_in = a_ff | top;
         mac_pkg::OP_MSB_B: b_in = b_ff | top;
         mac_pkg::OP_MSB_R: rep_in = rep_ff | top;
         mac_pkg::OP_MSB_S: src_in = src_ff | top;
         mac_pkg::OP_MSB_D: dst_in = dst_ff | top;
         mac_pkg::OP_MSB_SD: begin
            src_in = src_ff | top;
            dst_in = dst_ff | top;
         end
         mac_pkg::OP_MSB_P: peek_in = peek_ff | top;
         mac_pkg::OP_SWAP: begin
            a_in = b_ff;
            b_in = a_ff;
         end
         mac_pkg::OP_A2B:   b_in = a_ff;
         mac_pkg::OP_A2T:   tmp_in = a_ff;
         mac_pkg::OP_A2R:   rep_in = a_ff;
         mac_pkg::OP_A2S:   src_in = a_ff;
         mac_pkg::OP_A2D:   dst_in = a_ff;
         mac_pkg::OP_A2P:   peek_in = a_ff;
         mac_pkg::OP_A2PUT: put_in = a_ff;
         mac_pkg::OP_B2A:   a_in = b_ff;
         mac_pkg::OP_T2A:   a_in = tmp_ff;
         mac_pkg::OP_R2A:   a_in = rep_ff;
         mac_pkg::OP_S2A:   a_in = src_ff;
         mac_pkg::OP_D2A:   a_in = dst_ff;
         mac_pkg::OP_P2A:   a_in = peek_ff;
         mac_pkg::OP_PUT2A: a_in = put_ff;
         mac_pkg::OP_UNPARK0: peek_in = park_ff[0];
         mac_pkg::OP_UNPARK1: peek_in = park_ff[1];
         mac_pkg::OP_UNPARK2: peek_in = park_ff[2];
         mac_pkg::OP_UNPARK3: peek_in = park_ff[3];
         mac_pkg::OP_PARK0: park_in[0] = peek_ff;
         mac_pkg::OP_PARK1: park_in[1] = peek_ff;
         mac_pkg::OP_PARK2: park_in[2] = peek_ff;
         mac_pkg::OP_PARK3: park_in[3] = peek_ff;
         mac_pkg::OP_T_ZERO: taken = (a_ff == 32'd0);
         mac_pkg::OP_T_MIN:  taken = (a_ff == mac_pkg::SIGN_BIT);
         mac_pkg::OP_T_NEG:  taken = ((a_ff & mac_pkg::SIGN_BIT) != 32'd0);
         mac_pkg::OP_T_BIG:  taken = ((a_ff & mac_pkg::BIG_BIT) != 32'd0);
         mac_pkg::OP_T_EQ:   taken = (a_ff == b_ff);
         mac_pkg::OP_T_NE:   taken = (a_ff != b_ff);
         mac_pkg::OP_T_LE:   taken = (a_ff <= b_ff);
         mac_pkg::OP_T_GE:   taken = (a_ff >= b_ff);
         mac_pkg::OP_T_LT:   taken = (a_ff < b_ff);
         mac_pkg::OP_T_GT:   taken = (a_ff > b_ff);
         mac_pkg::OP_REPEAT: begin
            rep_in = rep_ff - 32'd1;
            taken = (rep_in != 32'd0);
         end
         mac_pkg::OP_MDM: a_in = 32'(mac_pkg::DATA_WORDS);
         default: ;
      endcase
      if (clr_busy_ff) begin
         mem_we = 1'b1;
         mem_wd = 32'd0;
         mem_addr = clr_cnt_ff;
      end else if (!go) begin
         mem_we = 1'b0;
      end
   end

   mac_ram #(
      .WIDTH (32),
      .DEPTH (mac_pkg::DATA_WORDS)
   ) u_dmem (
      .clock (clock),
      .we    (mem_we),
      .addr  (mem_addr),
      .wdata (mem_wd),
      .rdata (mem_rd)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_cnt_ff  <= '0;
         pend_ff     <= 1'b0;
         ov_ff       <= 1'b0;
         a_ff <= '0; b_ff <= '0; tmp_ff <= '0; put_ff <= '0;
         rep_ff <= '0; src_ff <= '0; dst_ff <= '0; peek_ff <= '0;
         park_ff <= '{default: '0};
      end else begin
         if (clr_busy_ff) begin
            clr_cnt_ff <= clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == mac_pkg::addr_type'(mac_pkg::DATA_WORDS - 1)) begin
               clr_busy_ff <= 1'b0;
            end
         end
         pend_ff <= go && is_load;
         if (pend_ff) begin
            a_ff  <= mem_rd;
            ov_ff <= 1'b1;
            od_ff <= mem_rd;
            ot_ff <= 1'b0;
         end else if (go) begin
            a_ff <= a_in; b_ff <= b_in; tmp_ff <= tmp_in; put_ff <= put_in;
            rep_ff <= rep_in; src_ff <= src_in; dst_ff <= dst_in;
            peek_ff <= peek_in; park_ff <= park_in;
            if (!is_load) begin
               ov_ff <= 1'b1;
               od_ff <= a_in;
               ot_ff <= taken;
            end else begin
               ov_ff <= 1'b0;
            end
         end else if (rsp_tready) begin
            ov_ff <= 1'b0;
         end
      end
   end

   assign rsp_tvalid = ov_ff;
   assign rsp_tdata  = od_ff;
   assign rsp_tuser  = ot_ff;

endmodule

/* rtl/mac_ram.sv */
// ----------------------------------------------------------------------------
// mac_ram
// single port synchronous ram, registered read
// ----------------------------------------------------------------------------
module mac_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata <= mem[addr];
   end

endmodule

/* tb/acc_checker.sv */
// ----------------------------------------------------------------------------
// acc_checker
// watches both channels of the accumulator execute core, predicts the
// accumulator and taken flag of every accepted instruction and compares
// ----------------------------------------------------------------------------
module acc_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [23:0] req_tdata,
   input  logic [6:0]  req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [31:0] rsp_tdata,
   input  logic        rsp_tuser,
   output int          fail_count,
   output int          pending,
   output int          taken_seen
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [31:0] acc;
      logic        taken;
   } outcome_type;

   logic [31:0] acc_r, opr_r, tmp_r, putv_r, rep_r, src_r, dst_r, pk_r;
   logic [31:0] park_r [4];
   logic [31:0] mem_r [mac_pkg::DATA_WORDS];
   outcome_type outcome_q [$];

   function automatic mac_pkg::addr_type word_at(logic [31:0] a);
      return mac_pkg::addr_type'((a & 32'h0fff_ffff) % mac_pkg::DATA_WORDS);
   endfunction

   task automatic execute(input logic [6:0] kind, input logic [23:0] imm);
      logic [31:0] a, b, iv, top;
      logic        tk;
      outcome_type o;
      a = acc_r;
      b = opr_r;
      iv = {8'h00, imm};
      top = {imm[7:0], 24'h0};
      tk = 1'b0;
      case (kind)
         mac_pkg::OP_ADD: acc_r = a + b;
         mac_pkg::OP_SUB: acc_r = a - b;
         mac_pkg::OP_OR: acc_r = a | b;
         mac_pkg::OP_AND: acc_r = a & b;
         mac_pkg::OP_XOR: acc_r = a ^ b;
         mac_pkg::OP_NOT: acc_r = ~a;
         mac_pkg::OP_NEG: acc_r = ~a + 32'd1;
         mac_pkg::OP_SHL: acc_r = a << b[4:0];
         mac_pkg::OP_SHR: acc_r = a >> b[4:0];
         mac_pkg::OP_LOAD: acc_r = mem_r[word_at(src_r)];
         mac_pkg::OP_STORE: mem_r[word_at(dst_r)] = a;
         mac_pkg::OP_GET: acc_r = mem_r[word_at(a)];
         mac_pkg::OP_PEEK: acc_r = mem_r[word_at(pk_r)];
         mac_pkg::OP_KEEP: mem_r[word_at(pk_r)] = a;
         mac_pkg::OP_PUT: mem_r[word_at(a)] = putv_r;
         mac_pkg::OP_INC_A: acc_r = a + 32'd1;
         mac_pkg::OP_DEC_A: acc_r = a - 32'd1;
         mac_pkg::OP_INC_S: src_r = src_r + 32'd1;
         mac_pkg::OP_DEC_S: src_r = src_r - 32'd1;
         mac_pkg::OP_INC_D: dst_r = dst_r + 32'd1;
         mac_pkg::OP_DEC_D: dst_r = dst_r - 32'd1;
         mac_pkg::OP_INC_SD: begin src_r = src_r + 32'd1; dst_r = dst_r + 32'd1; end
         mac_pkg::OP_DEC_SD: begin src_r = src_r - 32'd1; dst_r = dst_r - 32'd1; end
         mac_pkg::OP_INC_P: pk_r = pk_r + 32'd1;
         mac_pkg::OP_DEC_P: pk_r = pk_r - 32'd1;
         mac_pkg::OP_IMM_A: acc_r = iv;
         mac_pkg::OP_IMM_B: opr_r = iv;
         mac_pkg::OP_IMM_R: rep_r = iv;
         mac_pkg::OP_IMM_S: src_r = iv;
         mac_pkg::OP_IMM_D: dst_r = iv;
         mac_pkg::OP_IMM_SD: begin src_r = iv; dst_r = iv; end
         mac_pkg::OP_IMM_P: pk_r = iv;
         mac_pkg::OP_MSB_A: acc_r = acc_r | top;
         mac_pkg::OP_MSB_B: opr_r = opr_r | top;
         mac_pkg::OP_MSB_R: rep_r = rep_r | top;
         mac_pkg::OP_MSB_S: src_r = src_r | top;
         mac_pkg::OP_MSB_D: dst_r = dst_r | top;
         mac_pkg::OP_MSB_SD: begin src_r = src_r | top; dst_r = dst_r | top; end
         mac_pkg::OP_MSB_P: pk_r = pk_r | top;
         mac_pkg::OP_SWAP: begin acc_r = b; opr_r = a; end
         mac_pkg::OP_A2B: opr_r = a;
         mac_pkg::OP_A2T: tmp_r = a;
         mac_pkg::OP_A2R: rep_r = a;
         mac_pkg::OP_A2S: src_r = a;
         mac_pkg::OP_A2D: dst_r = a;
         mac_pkg::OP_A2P: pk_r = a;
         mac_pkg::OP_A2PUT: putv_r = a;
         mac_pkg::OP_B2A: acc_r = b;
         mac_pkg::OP_T2A: acc_r = tmp_r;
         mac_pkg::OP_R2A: acc_r = rep_r;
         mac_pkg::OP_S2A: acc_r = src_r;
         mac_pkg::OP_D2A: acc_r = dst_r;
         mac_pkg::OP_P2A: acc_r = pk_r;
         mac_pkg::OP_PUT2A: acc_r = putv_r;
         mac_pkg::OP_UNPARK0, mac_pkg::OP_UNPARK1, mac_pkg::OP_UNPARK2,
         mac_pkg::OP_UNPARK3:
            pk_r = park_r[2'(kind - mac_pkg::OP_UNPARK0)];
         mac_pkg::OP_PARK0, mac_pkg::OP_PARK1, mac_pkg::OP_PARK2, mac_pkg::OP_PARK3:
            park_r[2'(kind - mac_pkg::OP_PARK0)] = pk_r;
         mac_pkg::OP_T_ZERO: tk = (a == 32'd0);
         mac_pkg::OP_T_MIN: tk = (a == mac_pkg::SIGN_BIT);
         mac_pkg::OP_T_NEG: tk = a[31];
         mac_pkg::OP_T_BIG: tk = a[30];
         mac_pkg::OP_T_EQ: tk = (a == b);
         mac_pkg::OP_T_NE: tk = (a != b);
         mac_pkg::OP_T_LE: tk = (a <= b);
         mac_pkg::OP_T_GE: tk = (a >= b);
         mac_pkg::OP_T_LT: tk = (a < b);
         mac_pkg::OP_T_GT: tk = (a > b);
         mac_pkg::OP_REPEAT: begin rep_r = rep_r - 32'd1; tk = (rep_r != 32'd0); end
         mac_pkg::OP_MDM: acc_r = 32'(mac_pkg::DATA_WORDS);
         default: ;
      endcase
      o.acc = acc_r;
      o.taken = tk;
      outcome_q.push_back(o);
   endtask

   always @(posedge clock) begin
      outcome_type want;
      if (reset) begin
         acc_r <= 0; opr_r <= 0; tmp_r <= 0; putv_r <= 0;
         rep_r <= 0; src_r <= 0; dst_r <= 0; pk_r <= 0;
         for (int i = 0; i < 4; i++) park_r[i] <= 0;
         for (int i = 0; i < mac_pkg::DATA_WORDS; i++) mem_r[i] <= 0;
         outcome_q.delete();
         fail_count <= 0;
         taken_seen <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (outcome_q.size() == 0) begin
               $display("%0t: unexpected word acc=%h taken=%b", $time, rsp_tdata,
                        rsp_tuser);
               fail_count <= fail_count + 1;
            end else begin
               want = outcome_q.pop_front();
               if (want.acc !== rsp_tdata || want.taken !== rsp_tuser) begin
                  $display("%0t: mismatch expected acc=%h taken=%b actual acc=%h taken=%b",
                           $time, want.acc, want.taken, rsp_tdata, rsp_tuser);
                  fail_count <= fail_count + 1;
               end
               if (rsp_tuser === 1'b1) taken_seen <= taken_seen + 1;
            end
         end
         if (req_tvalid && req_tready) execute(req_tuser, req_tdata);
      end
   end

   assign pending = outcome_q.size();
endmodule

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// stimulus for the accumulator execute core: directed opcodes and corner
// values, then random instruction mixes with idling on both channels
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int IDLE_LIMIT = 20000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;
   logic [6:0]  req_tuser = mac_pkg::OP_NOP;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic        rsp_tuser;
   int          fail_count, pending, taken_seen;
   int          idle_cycles = 0;
   int          issued = 0;
   bit          sender_done = 1'b0;
   bit          paused = 1'b0;

   always #5 clock = ~clock;

   minimal_accumulator_core_execute_core DUT (.*);

   acc_checker checker_i (.*);

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // memory addresses are often small so stores and loads meet often
   function automatic logic [23:0] rand_imm();
      case ($urandom_range(0, 5))
         0: return 24'h000000;
         1: return 24'hffffff;
         2, 3: return 24'($urandom_range(0, 15));
         default: return 24'($urandom);
      endcase
   endfunction

   function automatic logic [6:0] rand_kind();
      int r;
      r = $urandom_range(0, 99);
      if (r < 3) return 7'($urandom_range(75, 127));
      if (r < 25) return 7'($urandom_range(mac_pkg::OP_LOAD, mac_pkg::OP_PUT));
      if (r < 35) return 7'($urandom_range(mac_pkg::OP_T_ZERO, mac_pkg::OP_REPEAT));
      return 7'($urandom_range(0, mac_pkg::OP_NOP));
   endfunction

   task automatic send(input logic [6:0] kind, input logic [23:0] imm);
      int g;
      g = gap_len();
      if (g != 0) begin
         req_tvalid <= 1'b0;
         repeat (g) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= kind;
      req_tdata <= imm;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      issued++;
   endtask

   always @(posedge clock) begin
      if (reset) rsp_tready <= 1'b0;
      else rsp_tready <= ($urandom_range(0, 9) < 7) || sender_done;
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset)
         idle_cycles <= 0;
      else if (idle_cycles < IDLE_LIMIT + 4096) idle_cycles <= idle_cycles + 1;
   end

   initial begin
      wait (idle_cycles == IDLE_LIMIT + 4096);
      $display("timeout after %0d idle cycles", idle_cycles);
      $display("testbench failed");
      $finish;
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      // directed: fill registers with corner values and touch every opcode
      send(mac_pkg::OP_IMM_A, 24'hffffff);
      send(mac_pkg::OP_MSB_A, 24'h0000ff);
      send(mac_pkg::OP_T_NEG, 24'h0);
      send(mac_pkg::OP_T_BIG, 24'h0);
      send(mac_pkg::OP_IMM_B, 24'h000021);
      send(mac_pkg::OP_SHL, 24'h0);
      send(mac_pkg::OP_SHR, 24'h0);
      send(mac_pkg::OP_IMM_A, 24'h0);
      send(mac_pkg::OP_MSB_A, 24'h000080);
      send(mac_pkg::OP_T_MIN, 24'h0);
      send(mac_pkg::OP_NEG, 24'h0);
      send(mac_pkg::OP_IMM_D, 24'hfff000);
      send(mac_pkg::OP_STORE, 24'h0);
      send(mac_pkg::OP_IMM_S, 24'h000000);
      send(mac_pkg::OP_MSB_S, 24'h0000f0);
      send(mac_pkg::OP_LOAD, 24'h0);
      send(mac_pkg::OP_IMM_R, 24'h000001);
      send(mac_pkg::OP_REPEAT, 24'h0);
      send(mac_pkg::OP_REPEAT, 24'h0);
      send(mac_pkg::OP_MDM, 24'h0);
      send(7'd127, 24'h5a5a5a);
      for (int k = 0; k <= mac_pkg::OP_NOP; k++) send(7'(k), rand_imm());
      req_tvalid <= 1'b0;
      @(posedge clock);
      wait (pending == 0);
      // random instructions mixed with well-formed store then load back sequences
      for (int i = 0; i < 455; i++) begin
         if (i >= 230 && !paused) begin
            paused = 1'b1;
            req_tvalid <= 1'b0;
            @(posedge clock);
            wait (pending == 0);
            @(posedge clock);
         end
         if ($urandom_range(0, 3) == 0) begin
            send(mac_pkg::OP_IMM_A, rand_imm());
            send(mac_pkg::OP_A2D, 24'h0);
            send(mac_pkg::OP_A2S, 24'h0);
            send(mac_pkg::OP_STORE, 24'h0);
            send(mac_pkg::OP_LOAD, 24'h0);
            i += 4;
         end else begin
            send(rand_kind(), rand_imm());
         end
      end
      req_tvalid <= 1'b0;
      sender_done = 1'b1;
      @(posedge clock);
      wait (pending == 0);
      repeat (10) @(posedge clock);
      $display("sent %0d instructions covering every opcode, corner immediates and",
               issued);
      $display("memory round trips; %0d words reported a taken condition", taken_seen);
      if (fail_count == 0) $display("testbench passed");
      else $display("testbench failed");
      $finish;
   end
endmodule
